@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the line buffer modules.
// Each one samples on clk and stays quiet during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every edge.
`define SCL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another one at the next edge.
`define SCL_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

@@ rtl/scl_pkg.sv @@
package scl_pkg;

  // Ring of stored characters.
  localparam int RING_DEPTH = 256;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  localparam logic [6:0] MAX_RUN = 7'd64;

  // Set-1 scancodes with a special meaning.
  localparam logic [7:0] SC_BACKSPACE  = 8'd14;
  localparam logic [7:0] SC_ENTER      = 8'd28;
  localparam logic [7:0] SC_LSHIFT     = 8'd42;
  localparam logic [7:0] SC_RSHIFT     = 8'd54;
  localparam logic [7:0] SC_ALT        = 8'd56;
  localparam logic [7:0] SC_CAPS       = 8'd58;
  localparam logic [7:0] SC_TABLE_SIZE = 8'd60;
  localparam logic [7:0] SC_LSHIFT_REL = 8'd170;
  localparam logic [7:0] SC_RSHIFT_REL = 8'd182;
  localparam logic [7:0] SC_DIGIT_LO   = 8'd2;
  localparam logic [7:0] SC_DIGIT_HI   = 8'd13;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  typedef enum logic [1:0] {
    OP_CHAR,
    OP_ENTER,
    OP_ERASE,
    OP_READ
  } op_code_t;

  typedef struct packed {
    op_code_t   op;
    logic [7:0] character;
    logic [6:0] count;
  } op_t;

  typedef enum logic [2:0] {
    KIND_ECHO_CHAR    = 3'd0,
    KIND_ECHO_NEWLINE = 3'd1,
    KIND_ECHO_ERASE   = 3'd2,
    KIND_READ_CHAR    = 3'd3,
    KIND_READ_REFUSED = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ_ADDR,
    ST_READ_DATA
  } back_state_t;

  // Key tables, padded to 64 so any 6-bit index is in range.
  localparam logic [7:0] PLAIN_KEYS [64] = '{
    8'h00, 8'h45, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h27, 8'hBF, 8'h42, 8'h20, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'hB4, 8'h2B, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h00,
    8'h7B, 8'h7C, 8'h4C, 8'h7D, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2D, 8'h00, 8'h2A, 8'h41, 8'h20, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] SHIFTED_KEYS [64] = '{
    8'h00, 8'h45, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2F, 8'h28,
    8'h29, 8'h3D, 8'h3F, 8'hA1, 8'h42, 8'h20, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'hA8, 8'h2A, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h00,
    8'h5B, 8'hB0, 8'h4C, 8'h5D, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3B, 8'h3A, 8'h5F, 8'h00, 8'h2A, 8'h41, 8'h20, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00
  };

endpackage

@@ rtl/scl_if.sv @@
interface scl_cmd_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] scancode;
  logic [6:0] read_count;

  modport source (output valid, command, scancode, read_count, input ready);
  modport sink (input valid, command, scancode, read_count, output ready);
endinterface

interface scl_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] character;
  logic       last;
  logic [6:0] granted;

  modport source (output valid, kind, character, last, granted, input ready);
  modport sink (input valid, kind, character, last, granted, output ready);
endinterface

@@ rtl/scancode_to_char_line_buffer_top.sv @@
// Channel  Dir  Payload
// cmd      in   command, scancode, read_count
// res      out  kind, character, last, granted
//
// A scancode or read word is accepted while the two-entry op queue has room.
// The back end handles a store, erase or refusal from its idle state; a read run leaves idle,
// then takes each character in two steps (address, then registered ring RAM data).
// Reset (rst, synchronous) clears shift state, counters and queue; no clearing pass.
// A stalled res holds the back end; cmd keeps flowing until the queue fills.
module scancode_to_char_line_buffer_top import scl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  scl_cmd_if.sink   cmd,
  scl_res_if.source res
);

  logic push;
  op_t  push_op;
  logic full;
  logic pop;
  op_t  pop_op;
  logic empty;

  scl_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .push    (push),
    .push_op (push_op),
    .full    (full)
  );

  scl_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (full),
    .pop     (pop),
    .pop_op  (pop_op),
    .empty   (empty)
  );

  scl_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (empty),
    .pop_op (pop_op),
    .pop    (pop),
    .res    (res)
  );

endmodule

@@ rtl/scl_ram.sv @@
module scl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/scl_queue.sv @@
`include "assert_macros.svh"

module scl_queue import scl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output op_t  pop_op,
  output logic empty
);

  op_t        entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full   = (count == 2'd2);
  assign empty  = (count == 2'd0);
  assign pop_op = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  `SCL_ASSERT(a_no_push_full, !(push && full), "push into full queue")
  `SCL_ASSERT(a_no_pop_empty, !(pop && empty), "pop from empty queue")

endmodule

@@ rtl/scl_front.sv @@
module scl_front import scl_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  scl_cmd_if.sink        cmd,
  output logic           push,
  output op_t            push_op,
  input  logic           full
);

  logic       lshift;
  logic       rshift;
  logic       caps;
  logic       lshift_next;
  logic       rshift_next;
  logic       caps_next;
  logic       accept;
  logic       digit;
  logic       use_shift;
  logic [5:0] key_idx;
  logic [7:0] code;

  assign cmd.ready = !full;
  assign accept    = cmd.valid && !full;
  assign code      = cmd.scancode;
  assign key_idx   = code[5:0];
  assign digit     = code inside {[SC_DIGIT_LO:SC_DIGIT_HI]};
  assign use_shift = (lshift | rshift) ^ (caps & ~digit);

  always_comb begin
    lshift_next       = lshift;
    rshift_next       = rshift;
    caps_next         = caps;
    push              = 1'b0;
    push_op.op        = OP_CHAR;
    push_op.character = use_shift ? SHIFTED_KEYS[key_idx] : PLAIN_KEYS[key_idx];
    push_op.count     = (cmd.read_count > MAX_RUN) ? MAX_RUN : cmd.read_count;
    if (accept) begin
      if (cmd.command) begin
        push       = 1'b1;
        push_op.op = OP_READ;
      end else if (code >= SC_TABLE_SIZE) begin
        if (code == SC_LSHIFT_REL) begin
          lshift_next = ~lshift;
        end
        if (code == SC_RSHIFT_REL) begin
          rshift_next = ~rshift;
        end
      end else begin
        case (code)
          SC_ENTER: begin
            push       = 1'b1;
            push_op.op = OP_ENTER;
          end
          SC_BACKSPACE: begin
            push       = 1'b1;
            push_op.op = OP_ERASE;
          end
          SC_LSHIFT: lshift_next = ~lshift;
          SC_RSHIFT: rshift_next = ~rshift;
          SC_ALT: ;
          SC_CAPS: caps_next = ~caps;
          default: begin
            push = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lshift <= 1'b0;
      rshift <= 1'b0;
      caps   <= 1'b0;
    end else begin
      lshift <= lshift_next;
      rshift <= rshift_next;
      caps   <= caps_next;
    end
  end

endmodule

@@ rtl/scl_back.sv @@
`include "assert_macros.svh"

module scl_back import scl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       empty,
  input  op_t        pop_op,
  output logic       pop,
  scl_res_if.source  res
);

  back_state_t state;
  back_state_t state_next;

  logic [15:0] line_length;
  logic [15:0] line_length_next;
  logic [15:0] write_count;
  logic [15:0] write_count_next;
  logic [15:0] read_total;
  logic [15:0] read_total_next;
  logic        line_ready;
  logic        line_ready_next;
  logic [6:0]  want;
  logic [6:0]  want_next;
  logic [6:0]  sent;
  logic [6:0]  sent_next;

  logic        res_valid;
  logic        res_valid_next;
  kind_t       res_kind;
  kind_t       res_kind_next;
  logic [7:0]  res_char;
  logic [7:0]  res_char_next;
  logic        res_last;
  logic        res_last_next;
  logic [6:0]  res_granted;
  logic [6:0]  res_granted_next;

  logic        out_free;
  logic [15:0] stored;
  logic        refused;
  logic        run_end;

  logic        ram_we;
  logic [7:0]  ram_wdata;
  logic        ram_re;
  logic [7:0]  ram_rdata;

  scl_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_count[RING_AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (read_total[RING_AW-1:0]),
    .rdata (ram_rdata)
  );

  assign res.valid     = res_valid;
  assign res.kind      = res_kind;
  assign res.character = res_char;
  assign res.last      = res_last;
  assign res.granted   = res_granted;

  assign out_free = !res_valid || res.ready;
  assign stored   = write_count - read_total;
  assign refused  = (pop_op.count == 7'd0) || !line_ready || (stored == 16'd0) ||
                    (stored < {9'd0, pop_op.count});
  assign run_end  = ((sent + 7'd1) == want) || (ram_rdata == CHAR_NEWLINE);

  always_comb begin
    state_next       = state;
    line_length_next = line_length;
    write_count_next = write_count;
    read_total_next  = read_total;
    line_ready_next  = line_ready;
    want_next        = want;
    sent_next        = sent;
    res_valid_next   = res_valid && !res.ready;
    res_kind_next    = res_kind;
    res_char_next    = res_char;
    res_last_next    = res_last;
    res_granted_next = res_granted;
    pop              = 1'b0;
    ram_we           = 1'b0;
    ram_wdata        = pop_op.character;
    ram_re           = 1'b0;

    case (state)
      ST_IDLE: begin
        if (!empty && out_free) begin
          pop              = 1'b1;
          res_last_next    = 1'b1;
          res_granted_next = 7'd0;
          res_char_next    = pop_op.character;
          case (pop_op.op)
            OP_CHAR: begin
              ram_we           = 1'b1;
              write_count_next = write_count + 16'd1;
              if (line_length != 16'hFFFF) begin
                line_length_next = line_length + 16'd1;
              end
              res_valid_next = 1'b1;
              res_kind_next  = KIND_ECHO_CHAR;
            end
            OP_ENTER: begin
              ram_we           = 1'b1;
              ram_wdata        = CHAR_NEWLINE;
              write_count_next = write_count + 16'd1;
              line_length_next = 16'd0;
              line_ready_next  = 1'b1;
              res_valid_next   = 1'b1;
              res_kind_next    = KIND_ECHO_NEWLINE;
              res_char_next    = CHAR_NEWLINE;
            end
            OP_ERASE: begin
              // drop backspace on an empty line
              if (line_length != 16'd0) begin
                line_length_next = line_length - 16'd1;
                write_count_next = write_count - 16'd1;
                res_valid_next   = 1'b1;
                res_kind_next    = KIND_ECHO_ERASE;
                res_char_next    = 8'd0;
              end
            end
            OP_READ: begin
              if (refused) begin
                res_valid_next = 1'b1;
                res_kind_next  = KIND_READ_REFUSED;
                res_char_next  = 8'd0;
              end else begin
                want_next  = pop_op.count;
                sent_next  = 7'd0;
                state_next = ST_READ_ADDR;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ_ADDR: begin
        ram_re     = 1'b1;
        state_next = ST_READ_DATA;
      end
      ST_READ_DATA: begin
        if (out_free) begin
          res_valid_next   = 1'b1;
          res_kind_next    = KIND_READ_CHAR;
          res_char_next    = ram_rdata;
          res_last_next    = run_end;
          res_granted_next = want;
          read_total_next  = read_total + 16'd1;
          sent_next        = sent + 7'd1;
          if (ram_rdata == CHAR_NEWLINE) begin
            line_ready_next = 1'b0;
          end
          state_next = run_end ? ST_IDLE : ST_READ_ADDR;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      line_length <= 16'd0;
      write_count <= 16'd0;
      read_total  <= 16'd0;
      line_ready  <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      line_length <= line_length_next;
      write_count <= write_count_next;
      read_total  <= read_total_next;
      line_ready  <= line_ready_next;
      res_valid   <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    want        <= want_next;
    sent        <= sent_next;
    res_kind    <= res_kind_next;
    res_char    <= res_char_next;
    res_last    <= res_last_next;
    res_granted <= res_granted_next;
  end

  `SCL_ASSERT(a_run_bound, (state == ST_IDLE) || (sent < want), "read run past its count")
  `SCL_ASSERT(a_run_stored, (state == ST_IDLE) || (write_count != read_total),
              "read run with nothing stored")
  `SCL_ASSERT_NEXT(a_addr_then_data, state == ST_READ_ADDR, state == ST_READ_DATA,
                   "ring read not followed by data step")

endmodule
